@@ rtl/core/kthmh_pkg.sv @@
// ============================================================================
// kthmh_pkg: shared types and constants for the kth-largest selector
// Holds payload structs, the engine status bundle and sizing defaults.
// ============================================================================
package kthmh_pkg;

    // Fixed field widths
    localparam int DATA_WIDTH    = 32;
    localparam int RANK_W        = 7;

    // Default heap depth (largest usable rank)
    localparam int MAX_RANK_DFLT = 64;

    // One input item
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         last;
    } kthmh_item_t;

    // One result item
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] kth_value;
        logic                         enough;
    } kthmh_result_t;

    // Engine status toward the top level
    typedef struct packed {
        logic busy;
        logic res_valid;
    } kthmh_eng_stat_t;

endpackage

@@ rtl/core/kthmh_sift_engine.sv @@
// ============================================================================
// kthmh_sift_engine: heap memory and sift sequencer
// Keeps a min-heap of the largest values of the current set in a two-read,
// one-write memory. A small sequencer walks one heap level per cycle with a
// signed compare stage, using a hole scheme (the moving value stays
// in a register and is written once at its final slot).
// ============================================================================
module kthmh_sift_engine #(
    parameter int MAX_RANK = kthmh_pkg::MAX_RANK_DFLT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  kthmh_pkg::kthmh_item_t      item,
    input  logic [$clog2(MAX_RANK+1)-1:0] k,
    input  logic                        res_take,
    output kthmh_pkg::kthmh_eng_stat_t  stat,
    output kthmh_pkg::kthmh_result_t    result
);

    localparam int DW = kthmh_pkg::DATA_WIDTH;
    localparam int CW = $clog2(MAX_RANK + 1);
    localparam int AW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int XW = CW + 1;

    // Sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UP   = 3'd1;
    localparam logic [2:0] S_DN   = 3'd2;
    localparam logic [2:0] S_PUT  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic signed [DW-1:0] cur_reg, cur_next;
    logic signed [DW-1:0] top_reg, top_next;
    logic                last_reg, last_next;

    // Heap memory: one write port, two registered read ports
    logic signed [DW-1:0] heap_mem [MAX_RANK];
    logic signed [DW-1:0] rda_reg, rdb_reg;
    logic                 we;
    logic [AW-1:0]        wa, ra_a, ra_b;
    logic signed [DW-1:0] wd;

    // Child / parent index helpers
    logic [XW-1:0]        lc_idx, rc_idx, nlc_idx;
    logic [AW-1:0]        parent_pos, child_pos;
    logic                 rc_ok, gt_vl, gt_rl, gt_vr, go_l, go_r;
    logic signed [DW-1:0] child_val;
    logic                 enough;

    // Read address of a right child, folded in range when past the end
    function automatic logic [AW-1:0] rc_addr(input logic [XW-1:0] rc);
        logic [XW-1:0] lim;
        lim = XW'(MAX_RANK);
        if (rc < lim)
            rc_addr = rc[AW-1:0];
        else
            rc_addr = AW'(rc - 1'b1);
    endfunction

    function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
        parent_of = (p - 1'b1) >> 1;
    endfunction

    // Memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            heap_mem[wa] <= wd;
        end
        rda_reg <= heap_mem[ra_a];
        rdb_reg <= heap_mem[ra_b];
    end

    // Compare stage on the current level
    always_comb
    begin
        lc_idx     = {{(XW-AW-1){1'b0}}, pos_reg, 1'b1};
        rc_idx     = lc_idx + 1'b1;
        rc_ok      = rc_idx < {1'b0, fill_reg};
        parent_pos = parent_of(pos_reg);
        gt_vl      = cur_reg > rda_reg;
        gt_rl      = rdb_reg > rda_reg;
        gt_vr      = cur_reg > rdb_reg;
        go_l       = rc_ok ? (gt_vl && gt_rl) : gt_vl;
        go_r       = rc_ok && !(gt_vl && gt_rl) && gt_vr;
        child_pos  = go_l ? lc_idx[AW-1:0] : rc_idx[AW-1:0];
        child_val  = go_l ? rda_reg : rdb_reg;
        nlc_idx    = {{(XW-AW-1){1'b0}}, child_pos, 1'b1};
        enough     = fill_reg >= k;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        pos_next   = pos_reg;
        cur_next   = cur_reg;
        top_next   = top_reg;
        last_next  = last_reg;
        we         = 1'b0;
        wa         = pos_reg;
        wd         = cur_reg;
        ra_a       = '0;
        ra_b       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cur_next  = item.value;
                    last_next = item.last;
                    if (fill_reg < k)
                    begin
                        // Append at the end, then sift up
                        pos_next  = fill_reg[AW-1:0];
                        fill_next = fill_reg + 1'b1;
                        if (fill_reg == '0)
                        begin
                            we         = 1'b1;
                            wa         = '0;
                            wd         = item.value;
                            top_next   = item.value;
                            state_next = item.last ? S_EMIT : S_IDLE;
                        end
                        else
                        begin
                            ra_a       = parent_of(fill_reg[AW-1:0]);
                            state_next = S_UP;
                        end
                    end
                    else if (item.value > top_reg)
                    begin
                        // Replace the top, then sift down
                        pos_next = '0;
                        if ({{(XW-1){1'b0}}, 1'b1} < {1'b0, fill_reg})
                        begin
                            ra_a       = AW'(1);
                            ra_b       = rc_addr(XW'(2));
                            state_next = S_DN;
                        end
                        else
                        begin
                            we         = 1'b1;
                            wa         = '0;
                            wd         = item.value;
                            top_next   = item.value;
                            state_next = item.last ? S_EMIT : S_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = item.last ? S_EMIT : S_IDLE;
                    end
                end
            end

            S_UP:
            begin
                we = 1'b1;
                if (rda_reg > cur_reg)
                begin
                    // Parent moves down into the hole
                    wd       = rda_reg;
                    pos_next = parent_pos;
                    if (parent_pos == '0)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        ra_a = parent_of(parent_pos);
                    end
                end
                else
                begin
                    state_next = last_reg ? S_EMIT : S_IDLE;
                end
            end

            S_DN:
            begin
                we = 1'b1;
                if (go_l || go_r)
                begin
                    // Smaller child moves up into the hole
                    wd       = child_val;
                    pos_next = child_pos;
                    if (pos_reg == '0)
                    begin
                        top_next = child_val;
                    end
                    if (nlc_idx < {1'b0, fill_reg})
                    begin
                        ra_a = nlc_idx[AW-1:0];
                        ra_b = rc_addr(nlc_idx + 1'b1);
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    if (pos_reg == '0)
                    begin
                        top_next = cur_reg;
                    end
                    state_next = last_reg ? S_EMIT : S_IDLE;
                end
            end

            S_PUT:
            begin
                we = 1'b1;
                if (pos_reg == '0)
                begin
                    top_next = cur_reg;
                end
                state_next = last_reg ? S_EMIT : S_IDLE;
            end

            S_EMIT:
            begin
                if (res_take)
                begin
                    fill_next  = '0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        cur_reg  <= cur_next;
        top_reg  <= top_next;
        last_reg <= last_next;
    end

    assign stat.busy        = state_reg != S_IDLE;
    assign stat.res_valid   = state_reg == S_EMIT;
    assign result.kth_value = enough ? top_reg : '0;
    assign result.enough    = enough;

endmodule

@@ rtl/core/kth_largest_min_heap.sv @@
// ============================================================================
// kth_largest_min_heap: streaming kth-largest selector
// Keeps the k largest values of each set in a min-heap and reports the heap
// top when the set's last value arrives.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  item    | in        | item_valid/item_stall | item_data (value, last)
//  res     | out       | res_valid/res_stall   | res_data (kth_value, enough)
//  cfg     | in        | cfg_valid/cfg_ready   | cfg_data (kth_rank)
//
// An item that is dropped or lands at the root is handled in the idle state;
// otherwise the sequencer sifts the value up or down, one heap level per cycle,
// which the registered reads of the heap memory allow.
// A last item adds an emit state that holds until the output register is free.
// Reset empties the heap and sets the rank to 1; no clearing pass is needed.
// item_stall is high while an item is in work; the output register lets a
// finished result wait under res_stall.
// ============================================================================
module kth_largest_min_heap #(
    parameter int MAX_RANK = kthmh_pkg::MAX_RANK_DFLT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  kthmh_pkg::kthmh_item_t        item_data,
    output logic                          res_valid,
    input  logic                          res_stall,
    output kthmh_pkg::kthmh_result_t      res_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kthmh_pkg::RANK_W-1:0]  cfg_data
);

    localparam int CW = $clog2(MAX_RANK + 1);

    logic [kthmh_pkg::RANK_W-1:0] rank_reg;
    logic [CW-1:0]                k_eff;
    logic                         start;
    logic                         res_take;
    logic                         out_valid_reg, out_valid_next;
    kthmh_pkg::kthmh_result_t     out_data_reg;
    kthmh_pkg::kthmh_eng_stat_t   stat;
    kthmh_pkg::kthmh_result_t     eng_result;

    // Rank register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= kthmh_pkg::RANK_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            rank_reg <= cfg_data;
        end
    end

    // Clamp rank to 1..MAX_RANK
    always_comb
    begin
        priority if (rank_reg == '0)
            k_eff = CW'(1);
        else if (int'(rank_reg) > MAX_RANK)
            k_eff = CW'(MAX_RANK);
        else
            k_eff = CW'(rank_reg);
    end

    assign start      = item_valid && !stat.busy;
    assign item_stall = stat.busy;

    kthmh_sift_engine #(
        .MAX_RANK (MAX_RANK)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (item_data),
        .k        (k_eff),
        .res_take (res_take),
        .stat     (stat),
        .result   (eng_result)
    );

    // Output register
    assign res_take = stat.res_valid && (!out_valid_reg || !res_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
            out_valid_next = 1'b1;
        else if (!res_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= eng_result;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

endmodule
